### rtl/core/i2cmws_pkg.sv
`timescale 1ns / 1ps
// Package for the I2C master write sequencer: action, outcome and status codes,
// and the structs passed between the controller, the transmit FIFO and the top level.
// No dependencies.
package i2cmws_pkg;

  localparam int FIFO_DEPTH_DEF = 16;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_SEND  = 2'd2;
  localparam logic [1:0] ACT_STOP  = 2'd3;

  localparam logic [1:0] WR_QUEUED  = 2'd0;
  localparam logic [1:0] WR_DROPPED = 2'd1;
  localparam logic [1:0] WR_REFUSED = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  localparam logic [3:0] ST_START     = 4'd0;
  localparam logic [3:0] ST_REPSTART  = 4'd1;
  localparam logic [3:0] ST_ADDR_ACK  = 4'd2;
  localparam logic [3:0] ST_DATA_ACK  = 4'd3;
  localparam logic [3:0] ST_ADDR_NACK = 4'd4;
  localparam logic [3:0] ST_DATA_NACK = 4'd5;
  localparam logic [3:0] ST_ARB_LOST  = 4'd6;
  localparam logic [3:0] ST_BUS_ERROR = 4'd7;

  localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       flush;
    logic [7:0] push_data;
  } fifo_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] rd_data;
  } fifo_sts_t;

  typedef struct packed {
    logic       error;
    logic       busy;
    logic [1:0] outcome;
    logic [7:0] bus_byte;
    logic [1:0] action;
  } result_t;

endpackage

### rtl/core/i2cmws_fifo.sv
`timescale 1ns / 1ps
// Transmit FIFO of the I2C master write sequencer, with a prefetched head byte.
// Depends on i2cmws_pkg.
module i2cmws_fifo #(
  parameter int FIFO_DEPTH = i2cmws_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cmws_pkg::fifo_ctl_t fifo_ctl,
  output i2cmws_pkg::fifo_sts_t fifo_sts
);
  import i2cmws_pkg::*;

  localparam int AW   = $clog2(FIFO_DEPTH);
  localparam int PW   = $clog2(2 * FIFO_DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(FIFO_DEPTH);
  localparam logic [PW-1:0] WRAP_P  = PW'(2 * FIFO_DEPTH - 1);
  localparam logic [PW:0]   SPAN_P  = (PW+1)'(2 * FIFO_DEPTH);

  logic [7:0]    mem [FIFO_DEPTH];
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [7:0]    rd_data_r;
  logic [PW:0]   count;
  logic [AW-1:0] wr_idx, rd_idx;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p == WRAP_P) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_idx(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return r[AW-1:0];
  endfunction

  always_comb begin
    if (tail_r >= head_r) begin
      count = {1'b0, tail_r} - {1'b0, head_r};
    end else begin
      count = {1'b0, tail_r} + SPAN_P - {1'b0, head_r};
    end
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (fifo_ctl.push) begin
      tail_nxt = ptr_inc(tail_r);
    end
    if (fifo_ctl.flush) begin
      head_nxt = tail_r;
    end else if (fifo_ctl.pop) begin
      head_nxt = ptr_inc(head_r);
    end
  end

  assign wr_idx = ptr_idx(tail_r);
  assign rd_idx = ptr_idx(head_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_ctl.push) begin
      mem[wr_idx] <= fifo_ctl.push_data;
    end
    if (fifo_ctl.push && (wr_idx == rd_idx)) begin
      rd_data_r <= fifo_ctl.push_data;
    end else begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign fifo_sts.empty   = (count == '0);
  assign fifo_sts.full    = (count >= (PW+1)'(FIFO_DEPTH));
  assign fifo_sts.rd_data = rd_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= (PW+1)'(FIFO_DEPTH))
    else $error("FIFO holds more entries than its depth");
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ctl.flush && !fifo_ctl.push |=> fifo_sts.empty)
    else $error("FIFO not empty after a flush");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ctl.push && !fifo_ctl.pop && !fifo_ctl.flush |=> !fifo_sts.empty)
    else $error("FIFO empty after a push");
`endif

endmodule

### rtl/core/i2cmws_ctrl.sv
`timescale 1ns / 1ps
// Sequencing control of the I2C master write sequencer: busy, error and
// end-pending flags, FIFO requests and the result of each item.
// Depends on i2cmws_pkg.
module i2cmws_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  proc,
  input  logic                  command,
  input  logic [7:0]            data,
  input  logic                  last_in,
  input  logic [3:0]            bus_status,
  input  logic [7:0]            target_address,
  input  i2cmws_pkg::fifo_sts_t fifo_sts,
  output i2cmws_pkg::fifo_ctl_t fifo_ctl,
  output i2cmws_pkg::result_t   result
);
  import i2cmws_pkg::*;

  logic busy_r, busy_nxt;
  logic error_r, error_nxt;
  logic end_r, end_nxt;

  always_comb begin
    busy_nxt           = busy_r;
    error_nxt          = error_r;
    end_nxt            = end_r;
    fifo_ctl.push      = 1'b0;
    fifo_ctl.pop       = 1'b0;
    fifo_ctl.flush     = 1'b0;
    fifo_ctl.push_data = data;
    result.action      = ACT_NONE;
    result.bus_byte    = '0;
    result.outcome     = WR_QUEUED;
    if (proc) begin
      if (command == CMD_WRITE) begin
        if (error_r) begin
          result.outcome = WR_DROPPED;
          if (last_in) begin
            error_nxt = 1'b0;
          end
        end else if (end_r || fifo_sts.full) begin
          result.outcome = WR_REFUSED;
        end else begin
          if (!busy_r) begin
            busy_nxt      = 1'b1;
            result.action = ACT_START;
          end
          fifo_ctl.push = 1'b1;
          end_nxt       = last_in;
        end
      end else begin
        unique case (bus_status)
          ST_START, ST_REPSTART: begin
            result.action   = ACT_SEND;
            result.bus_byte = target_address & ADDR_WRITE_MASK;
          end
          ST_ADDR_ACK: begin
            if (!fifo_sts.empty) begin
              fifo_ctl.pop    = 1'b1;
              result.action   = ACT_SEND;
              result.bus_byte = fifo_sts.rd_data;
            end
          end
          ST_DATA_ACK: begin
            if (!fifo_sts.empty) begin
              fifo_ctl.pop    = 1'b1;
              result.action   = ACT_SEND;
              result.bus_byte = fifo_sts.rd_data;
            end else begin
              busy_nxt      = 1'b0;
              end_nxt       = 1'b0;
              result.action = ACT_STOP;
            end
          end
          ST_ADDR_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_BUS_ERROR: begin
            fifo_ctl.flush = 1'b1;
            error_nxt      = 1'b1;
            end_nxt        = 1'b0;
            busy_nxt       = 1'b0;
            result.action  = ACT_STOP;
          end
          default: begin
          end
        endcase
      end
    end
    result.busy  = busy_nxt;
    result.error = error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      error_r <= 1'b0;
      end_r   <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      error_r <= error_nxt;
      end_r   <= end_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_error_event: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ctl.flush |=> error_r && !busy_r && !end_r && fifo_sts.empty)
    else $error("Error event did not leave the block idle with the error flag set");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ctl.push |-> !fifo_sts.full && !error_r && !end_r)
    else $error("Byte queued while writes are blocked");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_ctl.pop |-> !fifo_sts.empty)
    else $error("Byte popped from an empty FIFO");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    proc && result.action == ACT_START |=> busy_r)
    else $error("START requested without entering the busy state");
`endif

endmodule

### rtl/core/i2c_master_write_sequencer_top.sv
`timescale 1ns / 1ps
// I2C master write sequencer: top level with input register, controller,
// transmit FIFO and result register. Depends on i2cmws_pkg, i2cmws_ctrl, i2cmws_fifo.
// A result passes the input register and then the result register before it is offered.
// Throughput: one item per cycle while the receiver accepts results; the input and result registers are each one stage.
// Reset clears pointers, flags, the address register and valid bits; FIFO storage
// is not cleared and needs no clearing pass, so items are taken right after reset.
module i2c_master_write_sequencer_top #(
  parameter int FIFO_DEPTH = i2cmws_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data[7:0], bus_status[11:8], zero fill[15:12]
  input  logic        in_tuser,   // command[0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // bus_action[1:0], bus_byte[9:2], write_outcome[11:10],
                                  // busy_res[12], error[13], zero fill[15:14]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import i2cmws_pkg::*;

  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic [3:0] s1_status_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic [7:0] addr_r;
  logic       advance;
  fifo_ctl_t  fifo_ctl;
  fifo_sts_t  fifo_sts;
  result_t    result;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      addr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r    <= in_tuser;
      s1_data_r   <= in_tdata[7:0];
      s1_status_r <= in_tdata[11:8];
      s1_last_r   <= in_tlast;
    end
  end

  i2cmws_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .proc           (advance),
    .command        (s1_cmd_r),
    .data           (s1_data_r),
    .last_in        (s1_last_r),
    .bus_status     (s1_status_r),
    .target_address (addr_r),
    .fifo_sts       (fifo_sts),
    .fifo_ctl       (fifo_ctl),
    .result         (result)
  );

  i2cmws_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .fifo_ctl (fifo_ctl),
    .fifo_sts (fifo_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.error, out_res_r.busy, out_res_r.outcome,
                       out_res_r.bus_byte, out_res_r.action};

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_master_write_sequencer_top: host writes and bus events go
// in on the input stream and every bus result is checked against a cycle-free model of the
// sequencer. Depends on i2cmws_pkg and the sequencer RTL.
module tb;
  import i2cmws_pkg::*;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(2 * DEPTH);
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Model state of the sequencer.
  logic [7:0]       sh_fifo [DEPTH];
  logic [PTR_W-1:0] sh_head = '0;
  logic [PTR_W-1:0] sh_tail = '0;
  logic             sh_busy = 1'b0;
  logic             sh_error = 1'b0;
  logic             sh_end_pend = 1'b0;
  logic [7:0]       sh_addr = '0;

  result_t bus_results_q [$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      burst_left = 0;
  int      quiet_cycles = 0;
  bit      hold_req = 1'b0;

  i2c_master_write_sequencer_top #(.FIFO_DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] pop_tx_byte();
    logic [7:0] b;
    b = sh_fifo[sh_head % DEPTH];
    sh_head = sh_head + 1'b1;
    return b;
  endfunction

  function automatic result_t next_bus_result(input logic cmd, input logic [7:0] d,
                                              input logic lst, input logic [3:0] st);
    result_t          r;
    logic [PTR_W-1:0] cnt;
    r = '0;
    r.action = ACT_NONE;
    r.outcome = WR_QUEUED;
    cnt = sh_tail - sh_head;
    if (cmd == CMD_WRITE) begin
      if (sh_error) begin
        if (lst) sh_error = 1'b0;
        r.outcome = WR_DROPPED;
      end else if (sh_end_pend || cnt >= DEPTH) begin
        r.outcome = WR_REFUSED;
      end else begin
        if (!sh_busy) begin
          sh_busy = 1'b1;
          r.action = ACT_START;
        end
        sh_fifo[sh_tail % DEPTH] = d;
        sh_tail = sh_tail + 1'b1;
        sh_end_pend = lst;
      end
    end else begin
      case (st)
        ST_START, ST_REPSTART: begin
          r.action = ACT_SEND;
          r.bus_byte = sh_addr & ADDR_WRITE_MASK;
        end
        ST_ADDR_ACK: begin
          if (cnt != 0) begin
            r.action = ACT_SEND;
            r.bus_byte = pop_tx_byte();
          end
        end
        ST_DATA_ACK: begin
          if (cnt != 0) begin
            r.action = ACT_SEND;
            r.bus_byte = pop_tx_byte();
          end else begin
            sh_busy = 1'b0;
            sh_end_pend = 1'b0;
            r.action = ACT_STOP;
          end
        end
        ST_ADDR_NACK, ST_DATA_NACK, ST_ARB_LOST, ST_BUS_ERROR: begin
          sh_head = sh_tail;
          sh_error = 1'b1;
          sh_end_pend = 1'b0;
          sh_busy = 1'b0;
          r.action = ACT_STOP;
        end
        default: ;
      endcase
    end
    r.busy = sh_busy;
    r.error = sh_error;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_checker
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        bus_results_q.push_back(next_bus_result(in_tuser, in_tdata[7:0], in_tlast,
                                                in_tdata[11:8]));
      if (cfg_valid && cfg_ready)
        sh_addr = cfg_data;
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[13:0]);
        if (bus_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result 0x%0h arrived with nothing expected", out_tdata);
        end else begin
          want = bus_results_q.pop_front();
          check_field("bus_action", want.action, got.action);
          check_field("bus_byte", want.bus_byte, got.bus_byte);
          check_field("write_outcome", want.outcome, got.outcome);
          check_field("busy", want.busy, got.busy);
          check_field("error", want.error, got.error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver changes its stall pattern every so often; a hold request stops it for a
  // long stretch so that the sequencer fills up and stalls its input.
  initial begin : rx_stall_pattern
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            2: out_tready <= ($urandom_range(0, 7) != 0);
            default: out_tready <= ((tick % 8) >= 3);
          endcase
        end
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] d, input logic lst,
                           input logic [3:0] st);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, st, d};
    in_tuser <= cmd;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic host_write(input logic [7:0] d, input logic lst);
    send_item(CMD_WRITE, d, lst, 4'($urandom_range(0, 15)));
  endtask

  task automatic bus_event(input logic [3:0] st);
    send_item(CMD_EVENT, 8'($urandom), 1'($urandom), st);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (bus_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target_address(input logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One write transfer as a host would run it: queue the bytes, then walk the bus through
  // start, address and data acknowledges, sometimes broken off by an error event.
  task automatic run_transfer();
    int n;
    int k;
    bit inject;
    bit aborted;
    int inject_at;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
    inject = ($urandom_range(0, 4) == 0);
    inject_at = $urandom_range(0, n + 2);
    aborted = 1'b0;
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3))
        send_item(1'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
    for (k = 0; k < n; k++)
      host_write(8'($urandom), (k == n - 1) && ($urandom_range(0, 7) != 0));
    for (k = 0; k <= n + 2 && !aborted; k++) begin
      if (inject && k == inject_at) begin
        bus_event(4'($urandom_range(ST_ADDR_NACK, ST_BUS_ERROR)));
        repeat ($urandom_range(0, 2)) host_write(8'($urandom), 1'b0);
        host_write(8'($urandom), 1'b1);
        aborted = 1'b1;
      end else begin
        if (k == 0)
          bus_event(($urandom_range(0, 1) != 0) ? ST_REPSTART : ST_START);
        else if (k == 1)
          bus_event(ST_ADDR_ACK);
        else
          bus_event(ST_DATA_ACK);
        if ($urandom_range(0, 9) == 0) host_write(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic test_directed_cases();
    write_target_address(8'hA5);
    bus_event(ST_ADDR_ACK);
    bus_event(ST_DATA_ACK);
    bus_event(ST_START);
    bus_event(4'd8);
    bus_event(4'd15);
    host_write(8'h00, 1'b0);
    host_write(8'hFF, 1'b1);
    host_write(8'h5A, 1'b0);
    bus_event(ST_REPSTART);
    bus_event(ST_ADDR_ACK);
    bus_event(ST_DATA_ACK);
    bus_event(ST_DATA_ACK);
    host_write(8'h11, 1'b0);
    bus_event(ST_ADDR_NACK);
    host_write(8'h22, 1'b0);
    host_write(8'h33, 1'b1);
    bus_event(ST_DATA_NACK);
    host_write(8'h96, 1'b1);
    bus_event(ST_ARB_LOST);
    host_write(8'h69, 1'b1);
    bus_event(ST_BUS_ERROR);
    host_write(8'hC3, 1'b1);
    host_write(8'h44, 1'b1);
    bus_event(ST_START);
    bus_event(ST_ADDR_ACK);
    bus_event(ST_DATA_ACK);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    int goal;
    write_target_address(8'($urandom));
    hold_req = 1'b1;
    goal = items_sent + 40;
    while (items_sent < goal) run_transfer();
    drain_results();
    wait (hold_req == 1'b0);
  endtask

  task automatic test_random_transfers();
    logic [7:0] addr_set [4];
    int goal;
    addr_set = '{8'h00, 8'hFF, 8'h00, 8'h01};
    addr_set[2] = 8'($urandom);
    foreach (addr_set[i]) begin
      write_target_address(addr_set[i]);
      goal = items_sent + 100;
      while (items_sent < goal) run_transfer();
      drain_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_output_backpressure();
    test_random_transfers();
    if (mismatches == 0 && bus_results_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
